@@ src/integer_remainder_unit_assert.svh @@
// ----------------------------------------------------------------------------
// integer remainder unit assertion macros
// shared property forms for the checker, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef INTEGER_REMAINDER_UNIT_ASSERT_SVH
`define INTEGER_REMAINDER_UNIT_ASSERT_SVH

// property that must hold at every edge out of reset
`define IRU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define IRU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/iru_pkg.sv @@
// ----------------------------------------------------------------------------
// iru_pkg
// shared constants, element type codes and stage types of the remainder unit
// ----------------------------------------------------------------------------
`default_nettype none

package iru_pkg;

	// widest element handled by the cell chain, one cell per dividend bit
	localparam int MAX_WIDTH = 64;
	localparam int DATA_W    = 64;
	localparam int WIDTH_W   = $clog2(MAX_WIDTH) + 1;
	localparam int SBIT_W    = $clog2(MAX_WIDTH);

	// transfers in flight: front register, cells, output register, skid
	localparam int OUTSTANDING_MAX = MAX_WIDTH + 3;
	localparam int CNT_W           = $clog2(OUTSTANDING_MAX + 1) + 1;

	localparam logic [2:0] ET_INT8   = 3'd0;
	localparam logic [2:0] ET_UINT8  = 3'd1;
	localparam logic [2:0] ET_INT16  = 3'd2;
	localparam logic [2:0] ET_UINT16 = 3'd3;
	localparam logic [2:0] ET_INT32  = 3'd4;
	localparam logic [2:0] ET_UINT32 = 3'd5;
	localparam logic [2:0] ET_INT64  = 3'd6;
	localparam logic [2:0] ET_UINT64 = 3'd7;

	localparam logic [2:0] ET_RESET = ET_INT64;

	typedef struct packed {
		logic [MAX_WIDTH-1:0] rem;   // partial remainder
		logic [MAX_WIDTH-1:0] dvd;   // dividend magnitude, msb first
		logic [MAX_WIDTH-1:0] dsr;   // divisor magnitude
		logic                 neg;   // negate the remainder at the end
		logic                 sgn;   // signed element type
		logic                 zero;  // zero divisor, result forced to zero
		logic                 last;
	} stage_t;

	typedef struct packed {
		logic [DATA_W-1:0] remainder;
		logic              last;
	} out_t;

	// element width in bits, capped at the chain length
	function automatic logic [WIDTH_W-1:0] elem_width(input logic [2:0] et);
		int w;
		case (et)
			ET_INT8, ET_UINT8:   w = 8;
			ET_INT16, ET_UINT16: w = 16;
			ET_INT32, ET_UINT32: w = 32;
			default:             w = 64;
		endcase
		if (w > MAX_WIDTH) begin
			w = MAX_WIDTH;
		end
		return WIDTH_W'(w);
	endfunction

	function automatic logic elem_signed(input logic [2:0] et);
		logic s;
		case (et)
			ET_INT8, ET_INT16, ET_INT32, ET_INT64: s = 1'b1;
			default:                               s = 1'b0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

@@ src/iru_prep.sv @@
// ----------------------------------------------------------------------------
// iru_prep
// cuts operands to element width and takes magnitudes for the cell chain
// ----------------------------------------------------------------------------
`default_nettype none

module iru_prep (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire logic [63:0]         dividend,
	input  wire logic [63:0]         divisor,
	input  wire logic                last_in,
	input  wire logic [2:0]          etype,
	output      logic                valid_s1,
	output      iru_pkg::stage_t     stage_s1
);

	logic [iru_pkg::WIDTH_W-1:0]   w;
	logic [iru_pkg::SBIT_W-1:0]    sidx;
	logic [iru_pkg::MAX_WIDTH-1:0] mask;
	logic [iru_pkg::MAX_WIDTH-1:0] a;
	logic [iru_pkg::MAX_WIDTH-1:0] b;
	logic [iru_pkg::MAX_WIDTH-1:0] x;
	logic [iru_pkg::MAX_WIDTH-1:0] y;
	logic                          sgn;
	logic                          xneg;
	logic                          yneg;
	iru_pkg::stage_t               nxt;

	always_comb begin
		w    = iru_pkg::elem_width(etype);
		sgn  = iru_pkg::elem_signed(etype);
		sidx = iru_pkg::SBIT_W'(w - iru_pkg::WIDTH_W'(1));
		if (w >= iru_pkg::WIDTH_W'(iru_pkg::MAX_WIDTH)) begin
			mask = '1;
		end else begin
			mask = (iru_pkg::MAX_WIDTH'(1) << w) - iru_pkg::MAX_WIDTH'(1);
		end
		a    = dividend[iru_pkg::MAX_WIDTH-1:0] & mask;
		b    = divisor[iru_pkg::MAX_WIDTH-1:0] & mask;
		xneg = sgn & a[sidx];
		yneg = sgn & b[sidx];
		// sign-extend to chain width, then magnitude
		x    = xneg ? (a | ~mask) : a;
		y    = yneg ? (b | ~mask) : b;
		nxt.rem  = '0;
		nxt.dvd  = xneg ? (iru_pkg::MAX_WIDTH'(0) - x) : x;
		nxt.dsr  = yneg ? (iru_pkg::MAX_WIDTH'(0) - y) : y;
		nxt.neg  = xneg;
		nxt.sgn  = sgn;
		nxt.zero = (b == '0);
		nxt.last = last_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ src/iru_cell.sv @@
// ----------------------------------------------------------------------------
// iru_cell
// one restoring division step: shift in a dividend bit, trial subtract
// ----------------------------------------------------------------------------
`default_nettype none

module iru_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire iru_pkg::stage_t d,
	output      logic            valid_q,
	output      iru_pkg::stage_t q
);

	logic [iru_pkg::MAX_WIDTH:0] trial;
	logic [iru_pkg::MAX_WIDTH:0] diff;
	iru_pkg::stage_t             nxt;

	always_comb begin
		trial = {d.rem, d.dvd[iru_pkg::MAX_WIDTH-1]};
		diff  = trial - {1'b0, d.dsr};
		nxt   = d;
		// borrow out means the divisor did not fit
		nxt.rem = diff[iru_pkg::MAX_WIDTH] ? trial[iru_pkg::MAX_WIDTH-1:0]
		                                   : diff[iru_pkg::MAX_WIDTH-1:0];
		nxt.dvd = {d.dvd[iru_pkg::MAX_WIDTH-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ src/iru_post.sv @@
// ----------------------------------------------------------------------------
// iru_post
// sign fix and width extension of the remainder, output register and skid
// ----------------------------------------------------------------------------
`default_nettype none

module iru_post (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pipe_valid,
	input  wire iru_pkg::stage_t pipe,
	input  wire logic            out_ready,
	output      logic            pipe_en,
	output      logic            out_valid,
	output      iru_pkg::out_t   out
);

	logic [iru_pkg::MAX_WIDTH-1:0] res_mw;
	iru_pkg::out_t                 res;
	iru_pkg::out_t                 out_q;
	iru_pkg::out_t                 skid_q;
	logic                          out_valid_q;
	logic                          skid_valid_q;
	logic                          out_load;

	always_comb begin
		if (pipe.zero) begin
			res_mw = '0;
		end else if (pipe.neg) begin
			res_mw = iru_pkg::MAX_WIDTH'(0) - pipe.rem;
		end else begin
			res_mw = pipe.rem;
		end
		res.remainder = iru_pkg::DATA_W'(res_mw);
		if (pipe.sgn && res_mw[iru_pkg::MAX_WIDTH-1]) begin
			res.remainder = res.remainder
			              | ~iru_pkg::DATA_W'({iru_pkg::MAX_WIDTH{1'b1}});
		end
		res.last = pipe.last;
	end

	assign out_load  = !out_valid_q || out_ready;
	assign pipe_en   = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_load) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= pipe_valid;
			end
		end else if (pipe_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (pipe_valid && !skid_valid_q) begin
			skid_q <= res;
		end
	end

endmodule

`default_nettype wire

@@ src/integer_remainder_unit.sv @@
// ----------------------------------------------------------------------------
// integer_remainder_unit
// element-wise truncated integer remainder over streamed operand pairs
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                               marker
//  s_*       in         tdata: dividend[63:0], divisor[127:64] tlast: last_in
//  m_*       out        tdata: remainder[63:0]                tlast: last_out
//  cfg_*     in         cfg_wdata: element_type[2:0]          write on cfg_we
//
//  one transfer accepted per cycle while s_tready is high, one result per transfer, in order
//  a transfer passes the operand register, one cell per dividend bit, output register
//  reset clears the valid bits and sets element_type to int64
//  a stalled result sits in the output register, one more in the skid stage;
//  s_tready drops only while the skid stage is full and the whole chain holds
//
`default_nettype none

module integer_remainder_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// configuration
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_wdata,   // element_type
	// operand stream
	input  wire logic          s_tvalid,
	output      logic          s_tready,
	input  wire logic [127:0]  s_tdata,     // dividend [63:0], divisor [127:64]
	input  wire logic          s_tlast,     // last_in
	// result stream
	output      logic          m_tvalid,
	input  wire logic          m_tready,
	output      logic [63:0]   m_tdata,     // remainder [63:0]
	output      logic          m_tlast      // last_out
);

	// element type register, sampled by the front stage only
	logic [2:0] etype_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			etype_q <= iru_pkg::ET_RESET;
		end else if (cfg_we) begin
			etype_q <= cfg_wdata;
		end
	end

	// global advance: the whole chain moves unless the skid stage is full
	logic pipe_en;

	assign s_tready = pipe_en;

	// chain taps: index 0 is the front register, index MAX_WIDTH the last cell
	logic [iru_pkg::MAX_WIDTH:0] chain_v;
	iru_pkg::stage_t             chain_d [0:iru_pkg::MAX_WIDTH];

	iru_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (s_tvalid),
		.dividend (s_tdata[63:0]),
		.divisor  (s_tdata[127:64]),
		.last_in  (s_tlast),
		.etype    (etype_q),
		.valid_s1 (chain_v[0]),
		.stage_s1 (chain_d[0])
	);

	// one restoring step per cell, dividend msb first
	for (genvar i = 0; i < iru_pkg::MAX_WIDTH; i++) begin : g_cell
		iru_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (pipe_en),
			.in_valid (chain_v[i]),
			.d        (chain_d[i]),
			.valid_q  (chain_v[i+1]),
			.q        (chain_d[i+1])
		);
	end

	iru_pkg::out_t out;

	// sign fix on the magnitude remainder, then output register and skid
	iru_post u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.pipe_valid (chain_v[iru_pkg::MAX_WIDTH]),
		.pipe       (chain_d[iru_pkg::MAX_WIDTH]),
		.out_ready  (m_tready),
		.pipe_en    (pipe_en),
		.out_valid  (m_tvalid),
		.out        (out)
	);

	assign m_tdata = out.remainder;
	assign m_tlast = out.last;

endmodule

`default_nettype wire

@@ src/iru_checker.sv @@
// ----------------------------------------------------------------------------
// iru_checker
// port-level checks on output hold, occupancy, input stalls and results with no transfer
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_remainder_unit_assert.svh"

module iru_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [63:0] m_tdata,
	input  wire logic        m_tlast
);

	// transfers accepted but not yet delivered
	logic [iru_pkg::CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + iru_pkg::CNT_W'(s_tvalid && s_tready)
			               - iru_pkg::CNT_W'(m_tvalid && m_tready);
		end
	end

	`IRU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
	`IRU_ASSERT_ALWAYS(a_no_invent, !m_tvalid || (cnt_q != '0), "result without an accepted transfer")
	`IRU_ASSERT_ALWAYS(a_occupancy, cnt_q <= iru_pkg::CNT_W'(iru_pkg::OUTSTANDING_MAX), "more transfers in flight than storage")
	`IRU_ASSERT_ALWAYS(a_ready_cause, s_tready || m_tvalid, "input stalled with no result waiting")

endmodule

bind integer_remainder_unit iru_checker u_iru_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/integer_remainder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_remainder_checker
// watches the operand, result and config channels, predicts each remainder
// and compares it field by field with what the unit returns, in order
// ----------------------------------------------------------------------------

module integer_remainder_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [63:0]  m_tdata,
	input  logic         m_tlast,
	output int           errors,
	output int           pending
);

	typedef struct packed {
		logic [63:0] rem;
		logic        last;
	} rem_result_t;

	logic [2:0]  elem_type;
	rem_result_t expected_rem_q[$];
	int          mismatch_count = 0;

	assign errors = mismatch_count;

	function automatic int elem_bits(input logic [2:0] et);
		case (et)
			iru_pkg::ET_INT8, iru_pkg::ET_UINT8:   return 8;
			iru_pkg::ET_INT16, iru_pkg::ET_UINT16: return 16;
			iru_pkg::ET_INT32, iru_pkg::ET_UINT32: return 32;
			default:                               return 64;
		endcase
	endfunction

	// truncated remainder, sign follows the dividend
	function automatic logic [63:0] truncated_rem(input logic [63:0] dvd, input logic [63:0] dsr,
			input logic [2:0] et);
		int          w;
		logic        is_signed;
		logic [63:0] mask, x, y, ax, ay, r;
		w = elem_bits(et);
		is_signed = (et == iru_pkg::ET_INT8) || (et == iru_pkg::ET_INT16)
		         || (et == iru_pkg::ET_INT32) || (et == iru_pkg::ET_INT64);
		mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
		x = dvd & mask;
		y = dsr & mask;
		if (!is_signed) begin
			if (y == 64'd0) return 64'd0;
			return x % y;
		end
		if (w < 64 && x[w-1]) x = x | ~mask;
		if (w < 64 && y[w-1]) y = y | ~mask;
		ax = x[63] ? 64'd0 - x : x;
		ay = y[63] ? 64'd0 - y : y;
		if (ay == 64'd0) return 64'd0;
		r = ax % ay;
		return x[63] ? 64'd0 - r : r;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < 100) begin
			$display("[%0t] mismatch (type %0d): %s", $time, elem_type, what);
		end
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rem_result_t want;
		if (!arst_n) begin
			elem_type <= iru_pkg::ET_RESET;
			expected_rem_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we) elem_type <= cfg_wdata;
			if (s_tvalid && s_tready) begin
				want.rem  = truncated_rem(s_tdata[63:0], s_tdata[127:64], elem_type);
				want.last = s_tlast;
				expected_rem_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				if (expected_rem_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", m_tdata));
				end else begin
					want = expected_rem_q.pop_front();
					if (m_tdata !== want.rem)
						report_mismatch($sformatf("remainder %h, expected %h", m_tdata, want.rem));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
				end
			end
			pending <= expected_rem_q.size();
		end
	end

endmodule

@@ tb/tb_integer_remainder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_remainder_unit
// drives operand pairs through every element type with random gaps and
// back-pressure; the checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------

module tb_integer_remainder_unit;

	localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no transfer at all
	localparam int PRESSURE_CYCLES = 300;   // long receiver hold-off, fills the chain
	localparam int PRESSURE_ITEMS  = 100;   // more than the unit can hold
	localparam int PHASE_ITEMS     = 55;
	localparam int RANDOM_PHASES   = 16;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         cfg_we    = 1'b0;
	logic [2:0]   cfg_wdata = '0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata   = '0;   // dividend [63:0], divisor [127:64]
	logic         s_tlast   = 1'b0; // last_in
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [63:0]  m_tdata;          // remainder [63:0]
	logic         m_tlast;          // last_out

	int   errors;
	int   pending;
	int   idle_cycles   = 0;
	logic burst_mode    = 1'b0;     // sender offers back to back when set
	logic pressure_req  = 1'b0;     // sender asks for the long hold-off
	logic pressure_hold = 1'b0;     // receiver has started the long hold-off

	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ONES  = '1;

	always #5 clk = ~clk;

	integer_remainder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	integer_remainder_checker remainder_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.errors    (errors),
		.pending   (pending)
	);

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// operand of the element width with the interesting corners weighted in,
	// bits above the width left clear, sign-filled or filled with noise
	function automatic logic [63:0] pick_operand(input logic [2:0] et);
		int          w;
		logic [63:0] mask, v;
		w = int'(iru_pkg::elem_width(et));
		mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
		case ($urandom_range(0, 15))
			0:       v = 64'd0;
			1:       v = 64'd1;
			2:       v = ONES;
			3:       v = 64'd1 << (w - 1);
			4:       v = (64'd1 << (w - 1)) - 64'd1;
			5, 6:    v = 64'($urandom_range(1, 20));
			7:       v = 64'd0 - 64'($urandom_range(1, 20));
			default: v = {$urandom, $urandom};
		endcase
		v = v & mask;
		if (w < 64) begin
			case ($urandom_range(0, 2))
				0:       ;
				1:       if (v[w-1]) v = v | ~mask;
				default: v = v | ({$urandom, $urandom} & ~mask);
			endcase
		end
		return v;
	endfunction

	task automatic send_operands(input logic [63:0] dvd, input logic [63:0] dsr, input logic last);
		int gap;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {dsr, dvd};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and wait until every predicted result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_elem_type(input logic [2:0] et);
		cfg_wdata <= et;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// watchdog on cycles where nothing at all is transferred
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold-off while the sender keeps going
	initial begin : receiver
		int stall;
		@(posedge clk iff arst_n);
		forever begin
			if (!pressure_hold && pressure_req) begin
				pressure_hold = 1'b1;
				m_tready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// stimulus
	initial begin : stimulus
		logic [2:0]  et;
		logic [63:0] dvd, dsr, mask;
		int          w;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset type is int64: most negative by minus one, zero divisor, sign mixes
		send_operands(MIN64, ONES, 1'b0);
		send_operands(64'd7, 64'd0, 1'b0);
		send_operands(64'd0 - 64'd7, 64'd2, 1'b0);
		send_operands(64'd7, 64'd0 - 64'd2, 1'b0);
		send_operands(MIN64 - 64'd1, MIN64, 1'b0);
		send_operands(MIN64, MIN64 - 64'd1, 1'b0);
		send_operands(64'd0, ONES, 1'b1);
		drain_results();

		// int8, with noise above the element width
		write_elem_type(iru_pkg::ET_INT8);
		send_operands(64'hDEAD_BEEF_0000_0080, 64'h1234_5678_9ABC_DEFF, 1'b0);
		send_operands(64'hFFFF_FFFF_FFFF_FF05, 64'h5555_5555_5555_5500, 1'b0);
		send_operands(64'h80, 64'h07, 1'b0);
		send_operands(64'h7F, 64'h80, 1'b0);
		send_operands(64'h80, 64'h03, 1'b1);
		drain_results();

		// uint64 extremes
		write_elem_type(iru_pkg::ET_UINT64);
		send_operands(ONES, 64'd1, 1'b0);
		send_operands(ONES, MIN64, 1'b0);
		send_operands(64'd5, 64'd0, 1'b0);
		send_operands(MIN64, 64'd3, 1'b1);
		drain_results();

		// uint8, operand with the top bit set must not be read as negative
		write_elem_type(iru_pkg::ET_UINT8);
		send_operands(64'hA5A5_A5A5_A5A5_A5FF, 64'h0000_0000_0000_00FE, 1'b0);
		send_operands(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0100, 1'b1);
		drain_results();

		// receiver holds off while the sender offers back to back, the chain fills
		write_elem_type(iru_pkg::ET_INT32);
		pressure_req = 1'b1;
		wait (pressure_hold);
		burst_mode = 1'b1;
		for (int i = 0; i < PRESSURE_ITEMS; i++) begin
			dvd = pick_operand(iru_pkg::ET_INT32);
			dsr = pick_operand(iru_pkg::ET_INT32);
			send_operands(dvd, dsr, i == PRESSURE_ITEMS - 1);
		end
		burst_mode = 1'b0;
		drain_results();

		// random phases, every element type once in turn, then random types
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			et = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
			write_elem_type(et);
			burst_mode = ($urandom_range(0, 2) == 0);
			w = int'(iru_pkg::elem_width(et));
			mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 19) == 0) begin
					// most negative by minus one, high bits noisy
					dvd = ((64'd1 << (w - 1)) & mask) | ({$urandom, $urandom} & ~mask);
					dsr = mask | ({$urandom, $urandom} & ~mask);
				end else begin
					dvd = pick_operand(et);
					dsr = pick_operand(et);
				end
				send_operands(dvd, dsr, $urandom_range(0, 7) == 0);
			end
			drain_results();
		end

		// let any stray result show up before the verdict
		repeat (80) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
